// File: rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// Hit calibrate and event builder package
// Shared types, codes, mapping tables and saturation helpers.
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam int CH_W          = 10;
   localparam int TIME_W        = 48;
   localparam int RAW_W         = 20;
   localparam int COEF_W        = 32;
   localparam int SUM_W         = 48;
   localparam int CNT_W         = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int SCATTER_W     = 7;
   localparam int BLOCK_CH      = 128;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] MODE_HIT  = 2'd0;
   localparam logic [1:0] MODE_COEF = 2'd1;
   localparam logic [1:0] MODE_TCNT = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [1:0] MOD_ZERO    = 2'd0;
   localparam logic [1:0] MOD_ONE     = 2'd1;
   localparam logic [1:0] MOD_SCATTER = 2'd2;
   localparam logic [1:0] MOD_NONE    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCATTER = 2'd1;

   localparam logic [CH_W-1:0] CH_MOD0_LO = 10'd256;
   localparam logic [CH_W-1:0] CH_MOD1_LO = 10'd512;
   localparam logic [CH_W-1:0] CH_MOD1_HI = 10'd767;

   localparam logic [31:0] WINDOW_RESET  = 32'd20000;
   localparam logic [6:0]  SCATTER_RESET = 7'd21;

   localparam logic [2:0] COLUMN_ROM [BLOCK_CH] = '{
      3'd7,3'd6,3'd4,3'd6,3'd5,3'd7,3'd4,3'd6,3'd5,3'd3,3'd7,3'd4,3'd6,3'd5,3'd7,3'd4,
      3'd6,3'd7,3'd7,3'd6,3'd7,3'd6,3'd6,3'd7,3'd4,3'd5,3'd4,3'd5,3'd5,3'd5,3'd4,3'd4,
      3'd5,3'd3,3'd2,3'd2,3'd3,3'd2,3'd2,3'd3,3'd2,3'd3,3'd0,3'd1,3'd0,3'd1,3'd1,3'd0,
      3'd0,3'd1,3'd3,3'd0,3'd1,3'd1,3'd0,3'd0,3'd1,3'd2,3'd2,3'd3,3'd0,3'd2,3'd3,3'd1,
      3'd0,3'd1,3'd3,3'd1,3'd2,3'd0,3'd3,3'd1,3'd2,3'd4,3'd0,3'd3,3'd1,3'd2,3'd0,3'd3,
      3'd1,3'd0,3'd0,3'd1,3'd0,3'd1,3'd1,3'd0,3'd3,3'd2,3'd3,3'd2,3'd2,3'd2,3'd3,3'd3,
      3'd2,3'd4,3'd5,3'd5,3'd4,3'd5,3'd5,3'd4,3'd5,3'd4,3'd7,3'd6,3'd7,3'd6,3'd6,3'd7,
      3'd7,3'd6,3'd4,3'd7,3'd6,3'd6,3'd7,3'd7,3'd6,3'd5,3'd5,3'd4,3'd7,3'd5,3'd4,3'd6
   };

   localparam logic [3:0] ROW_ROM [BLOCK_CH] = '{
      4'd6,4'd6,4'd5,4'd7,4'd7,4'd4,4'd7,4'd5,4'd6,4'd4,4'd7,4'd4,4'd4,4'd5,4'd5,4'd6,
      4'd1,4'd0,4'd1,4'd0,4'd3,4'd3,4'd2,4'd2,4'd0,4'd0,4'd1,4'd4,4'd1,4'd2,4'd2,4'd3,
      4'd3,4'd3,4'd3,4'd2,4'd2,4'd1,4'd4,4'd1,4'd0,4'd0,4'd3,4'd3,4'd2,4'd1,4'd2,4'd1,
      4'd0,4'd0,4'd7,4'd4,4'd4,4'd5,4'd5,4'd6,4'd6,4'd7,4'd5,4'd6,4'd7,4'd6,4'd5,4'd7,
      4'd9,4'd9,4'd10,4'd8,4'd8,4'd11,4'd8,4'd10,4'd9,4'd11,4'd8,4'd11,4'd11,4'd10,4'd10,
      4'd9,4'd14,4'd15,4'd14,4'd15,4'd12,4'd12,4'd13,4'd13,4'd15,4'd15,4'd14,4'd11,4'd14,
      4'd13,4'd13,4'd12,4'd12,4'd12,4'd12,4'd13,4'd13,4'd14,4'd11,4'd14,4'd15,4'd15,4'd12,
      4'd12,4'd13,4'd14,4'd13,4'd14,4'd15,4'd15,4'd8,4'd11,4'd11,4'd10,4'd10,4'd9,4'd9,
      4'd8,4'd10,4'd9,4'd8,4'd9,4'd10,4'd8
   };

   typedef struct packed {
      logic [1:0]          mode;
      logic [CH_W-1:0]     channel;
      logic [TIME_W-1:0]   time_ps;
      logic [RAW_W-1:0]    raw_energy;
      logic [1:0]          term_index;
      logic [COEF_W-1:0]   coef_value;
      logic [2:0]          term_count;
      logic [1:0]          module_res;
      logic [2:0]          column;
      logic [3:0]          row;
   } item_type;

   typedef struct packed {
      logic                kind;
      logic [CH_W-1:0]     channel_out;
      logic [1:0]          module_res;
      logic [2:0]          column;
      logic [3:0]          row;
      logic [TIME_W-1:0]   time_value;
      logic [TIME_W-1:0]   offset_or_hits;
      logic [COEF_W-1:0]   energy_value;
      logic [SUM_W-1:0]    energy_module0;
      logic [SUM_W-1:0]    energy_module1;
      logic [CNT_W-1:0]    hits_module0;
      logic [CNT_W-1:0]    hits_module1;
   } result_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TCNT,
      ST_TCNT_WAIT,
      ST_COEF_READ,
      ST_COEF_LOAD,
      ST_MUL,
      ST_ADD,
      ST_WINDOW,
      ST_HIT
   } back_state_type;

   function automatic logic [COEF_W-1:0] sat32(input logic signed [52:0] v);
      logic [COEF_W-1:0] r;
      if (v > 53'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -53'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[COEF_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [SUM_W-1:0] sat48(input logic signed [SUM_W:0] v);
      logic [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) begin
         r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] inc16(input logic [CNT_W-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

endpackage

// File: rtl/hcb_if.sv
// ----------------------------------------------------------------------------
// Hit calibrate and event builder channels
// Valid/ready interfaces for the item, result and register write channels.
// ----------------------------------------------------------------------------
interface hcb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [9:0]  channel;
   logic [47:0] time_ps;
   logic [19:0] raw_energy;
   logic [1:0]  term_index;
   logic [31:0] coef_value;
   logic [2:0]  term_count;
   modport source (output valid, mode, channel, time_ps, raw_energy, term_index,
                   coef_value, term_count, input ready);
   modport sink (input valid, mode, channel, time_ps, raw_energy, term_index,
                 coef_value, term_count, output ready);
endinterface

interface hcb_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [9:0]  channel_out;
   logic [1:0]  module_res;
   logic [2:0]  column;
   logic [3:0]  row;
   logic [47:0] time_value;
   logic [47:0] offset_or_hits;
   logic [31:0] energy_value;
   logic [47:0] energy_module0;
   logic [47:0] energy_module1;
   logic [15:0] hits_module0;
   logic [15:0] hits_module1;
   modport source (output valid, kind, channel_out, module_res, column, row, time_value,
                   offset_or_hits, energy_value, energy_module0, energy_module1,
                   hits_module0, hits_module1, input ready);
   modport sink (input valid, kind, channel_out, module_res, column, row, time_value,
                 offset_or_hits, energy_value, energy_module0, energy_module1,
                 hits_module0, hits_module1, output ready);
endinterface

interface hcb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/hcb_front.sv
// ----------------------------------------------------------------------------
// Hit calibrate and event builder front end
// Accepts items, drops unused modes and classifies module and crystal position.
// ----------------------------------------------------------------------------
module hcb_front
   import hcb_pkg::*;
(
   input  logic                 reset,
   hcb_req_if.sink              req_bus,
   input  logic [SCATTER_W-1:0] scatter_channel,
   input  logic                 clearing,
   input  logic                 q_full,
   output logic                 q_push,
   output item_type             q_item
);

   logic [6:0] blk_idx;

   assign req_bus.ready = !q_full && !clearing && !reset;
   assign q_push = req_bus.valid && req_bus.ready && (req_bus.mode != MODE_NONE);
   assign blk_idx = req_bus.channel[6:0];

   always_comb begin
      q_item.mode       = req_bus.mode;
      q_item.channel    = req_bus.channel;
      q_item.time_ps    = req_bus.time_ps;
      q_item.raw_energy = req_bus.raw_energy;
      q_item.term_index = req_bus.term_index;
      q_item.coef_value = req_bus.coef_value;
      q_item.term_count = req_bus.term_count;
      q_item.column     = COLUMN_ROM[blk_idx];
      q_item.row        = ROW_ROM[blk_idx];
      if (req_bus.channel inside {[CH_MOD0_LO:CH_MOD1_LO-10'd1]}) begin
         q_item.module_res = MOD_ZERO;
      end else if (req_bus.channel inside {[CH_MOD1_LO:CH_MOD1_HI]}) begin
         q_item.module_res = MOD_ONE;
      end else if (req_bus.channel == {3'd0, scatter_channel}) begin
         q_item.module_res = MOD_SCATTER;
      end else begin
         q_item.module_res = MOD_NONE;
      end
   end

endmodule

// File: rtl/hcb_fifo.sv
// ----------------------------------------------------------------------------
// Hit calibrate and event builder queue
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module hcb_fifo
   import hcb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   item_type          store_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in;
   logic [PW-1:0]     rd_ff, rd_in;
   logic [PW:0]       cnt_ff, cnt_in;

   assign full       = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = store_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/hcb_back.sv
// ----------------------------------------------------------------------------
// Hit calibrate and event builder back end
// Coefficient stores, Horner evaluation on one multiplier and window building.
// ----------------------------------------------------------------------------
module hcb_back
   import hcb_pkg::*;
#(
   parameter int NUM_CHANNELS = 1024,
   parameter int MAX_TERMS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   input  logic [31:0] window_ps,
   output logic        clearing,
   hcb_rsp_if.source   rsp_bus
);

   localparam int NCW   = $clog2(NUM_CHANNELS);
   localparam int CW    = $clog2(MAX_TERMS + 1);
   localparam int DEPTH = NUM_CHANNELS * MAX_TERMS;
   localparam int AW    = $clog2(DEPTH);

   logic [COEF_W-1:0] coef_mem [DEPTH];
   logic [CW-1:0]     tcnt_mem [NUM_CHANNELS];

   back_state_type    state_ff, state_in;
   logic [NCW-1:0]    clr_ff, clr_in;
   item_type          work_ff, work_in;
   logic [CW-1:0]     tcnt_rd_ff;
   logic [COEF_W-1:0] coef_rd_ff;
   logic [CW-1:0]     ci_ff, ci_in;
   logic [COEF_W-1:0] acc_ff, acc_in;
   logic signed [52:0] prod_ff, prod_in;
   logic              started_ff, started_in;
   logic [TIME_W-1:0] ws_ff, ws_in;
   logic [CNT_W-1:0]  tot_ff, tot_in;
   logic [CNT_W-1:0]  h0_ff, h0_in;
   logic [CNT_W-1:0]  h1_ff, h1_in;
   logic [SUM_W-1:0]  s0_ff, s0_in;
   logic [SUM_W-1:0]  s1_ff, s1_in;
   logic [COEF_W-1:0] sc_ff, sc_in;
   result_type        res_ff, res_in;
   logic              res_v_ff, res_v_in;

   logic              coef_we;
   logic [AW-1:0]     coef_wa;
   logic [AW-1:0]     coef_ra;
   logic              tcnt_we;
   logic [NCW-1:0]    tcnt_wa;
   logic [CW-1:0]     tcnt_wd;
   logic              slot_free;
   logic              head_in_range;
   logic              work_in_range;
   logic [CW-1:0]     tcnt_clip;
   logic [CW-1:0]     n_terms;
   logic              close_win;
   logic signed [52:0] shifted;
   logic signed [SUM_W:0] e_ext;

   assign clearing      = (state_ff == ST_CLEAR);
   assign slot_free     = !res_v_ff || rsp_bus.ready;
   assign head_in_range = ({1'b0, head_item.channel} < (CH_W+1)'(NUM_CHANNELS));
   assign work_in_range = ({1'b0, work_ff.channel} < (CH_W+1)'(NUM_CHANNELS));
   assign tcnt_clip     = ({1'b0, head_item.term_count} > 4'(MAX_TERMS)) ?
                          CW'(MAX_TERMS) : CW'(head_item.term_count);
   assign n_terms       = work_in_range ? tcnt_rd_ff : '0;
   assign coef_wa       = AW'(32'(head_item.channel) * MAX_TERMS + 32'(head_item.term_index));
   assign coef_ra       = AW'(32'(work_ff.channel) * MAX_TERMS + 32'(ci_ff));
   assign close_win     = started_ff &&
                          ({1'b0, work_ff.time_ps} > ({1'b0, ws_ff} + 49'(window_ps)));
   assign shifted       = prod_ff >>> 8;
   assign e_ext         = (SUM_W+1)'($signed(acc_ff));

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      work_in    = work_ff;
      ci_in      = ci_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      started_in = started_ff;
      ws_in      = ws_ff;
      tot_in     = tot_ff;
      h0_in      = h0_ff;
      h1_in      = h1_ff;
      s0_in      = s0_ff;
      s1_in      = s1_ff;
      sc_in      = sc_ff;
      res_in     = res_ff;
      res_v_in   = res_v_ff && !rsp_bus.ready;
      pop        = 1'b0;
      coef_we    = 1'b0;
      tcnt_we    = 1'b0;
      tcnt_wa    = head_item.channel[NCW-1:0];
      tcnt_wd    = tcnt_clip;
      case (state_ff)
         ST_CLEAR: begin
            tcnt_we = 1'b1;
            tcnt_wa = clr_ff;
            tcnt_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == NCW'(NUM_CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               work_in = head_item;
               case (head_item.mode)
                  MODE_COEF: begin
                     coef_we = head_in_range && (32'(head_item.term_index) < MAX_TERMS);
                  end
                  MODE_TCNT: begin
                     tcnt_we = head_in_range;
                  end
                  default: begin
                     state_in = ST_TCNT;
                  end
               endcase
            end
         end
         ST_TCNT: begin
            state_in = ST_TCNT_WAIT;
         end
         ST_TCNT_WAIT: begin
            if (n_terms == '0) begin
               acc_in   = '0;
               state_in = ST_WINDOW;
            end else begin
               ci_in    = n_terms - 1'b1;
               state_in = ST_COEF_READ;
            end
         end
         ST_COEF_READ: begin
            state_in = ST_COEF_LOAD;
         end
         ST_COEF_LOAD: begin
            acc_in = coef_rd_ff;
            if (ci_ff == '0) begin
               state_in = ST_WINDOW;
            end else begin
               ci_in    = ci_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 53'($signed(acc_ff)) * 53'($signed({1'b0, work_ff.raw_energy}));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in = sat32(53'($signed(sat32(shifted))) + 53'($signed(coef_rd_ff)));
            if (ci_ff == '0) begin
               state_in = ST_WINDOW;
            end else begin
               ci_in    = ci_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_WINDOW: begin
            if (close_win) begin
               if (slot_free) begin
                  res_v_in              = 1'b1;
                  res_in.kind           = 1'b1;
                  res_in.channel_out    = '0;
                  res_in.module_res     = MOD_NONE;
                  res_in.column         = '0;
                  res_in.row            = '0;
                  res_in.time_value     = ws_ff;
                  res_in.offset_or_hits = TIME_W'(tot_ff);
                  res_in.energy_value   = sc_ff;
                  res_in.energy_module0 = s0_ff;
                  res_in.energy_module1 = s1_ff;
                  res_in.hits_module0   = h0_ff;
                  res_in.hits_module1   = h1_ff;
                  tot_in   = '0;
                  h0_in    = '0;
                  h1_in    = '0;
                  s0_in    = '0;
                  s1_in    = '0;
                  sc_in    = '0;
                  ws_in    = work_ff.time_ps;
                  state_in = ST_HIT;
               end
            end else begin
               started_in = 1'b1;
               if (!started_ff) begin
                  ws_in = work_ff.time_ps;
               end
               state_in = ST_HIT;
            end
         end
         ST_HIT: begin
            if (slot_free) begin
               res_v_in              = 1'b1;
               res_in.kind           = 1'b0;
               res_in.channel_out    = work_ff.channel;
               res_in.module_res     = work_ff.module_res;
               res_in.column         = work_ff.column;
               res_in.row            = work_ff.row;
               res_in.time_value     = work_ff.time_ps;
               res_in.offset_or_hits = work_ff.time_ps - ws_ff;
               res_in.energy_value   = acc_ff;
               res_in.energy_module0 = '0;
               res_in.energy_module1 = '0;
               res_in.hits_module0   = '0;
               res_in.hits_module1   = '0;
               tot_in = inc16(tot_ff);
               case (work_ff.module_res)
                  MOD_ZERO: begin
                     s0_in = sat48((SUM_W+1)'($signed(s0_ff)) + e_ext);
                     h0_in = inc16(h0_ff);
                  end
                  MOD_ONE: begin
                     s1_in = sat48((SUM_W+1)'($signed(s1_ff)) + e_ext);
                     h1_in = inc16(h1_ff);
                  end
                  MOD_SCATTER: begin
                     sc_in = acc_ff;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         started_ff <= 1'b0;
         ws_ff      <= '0;
         tot_ff     <= '0;
         h0_ff      <= '0;
         h1_ff      <= '0;
         s0_ff      <= '0;
         s1_ff      <= '0;
         sc_ff      <= '0;
         res_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         started_ff <= started_in;
         ws_ff      <= ws_in;
         tot_ff     <= tot_in;
         h0_ff      <= h0_in;
         h1_ff      <= h1_in;
         s0_ff      <= s0_in;
         s1_ff      <= s1_in;
         sc_ff      <= sc_in;
         res_v_ff   <= res_v_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      ci_ff   <= ci_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= head_item.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_ra];
   end

   always_ff @(posedge clock) begin
      if (tcnt_we) begin
         tcnt_mem[tcnt_wa] <= tcnt_wd;
      end
      tcnt_rd_ff <= tcnt_mem[work_ff.channel[NCW-1:0]];
   end

   assign rsp_bus.valid          = res_v_ff;
   assign rsp_bus.kind           = res_ff.kind;
   assign rsp_bus.channel_out    = res_ff.channel_out;
   assign rsp_bus.module_res     = res_ff.module_res;
   assign rsp_bus.column         = res_ff.column;
   assign rsp_bus.row            = res_ff.row;
   assign rsp_bus.time_value     = res_ff.time_value;
   assign rsp_bus.offset_or_hits = res_ff.offset_or_hits;
   assign rsp_bus.energy_value   = res_ff.energy_value;
   assign rsp_bus.energy_module0 = res_ff.energy_module0;
   assign rsp_bus.energy_module1 = res_ff.energy_module1;
   assign rsp_bus.hits_module0   = res_ff.hits_module0;
   assign rsp_bus.hits_module1   = res_ff.hits_module1;

endmodule

// File: rtl/hit_calibrate_and_event_builder.sv
// ----------------------------------------------------------------------------
// Hit calibrate and event builder
// Calibrates time-sorted detector hits and groups them into time windows.
//
//   Channel   Direction  Carries
//   req_bus   in         hits, coefficient writes, term count writes
//   rsp_bus   out        hit records and closed-window summaries
//   csr_bus   in         window length and scatter channel writes
//
// A hit with n calibration terms is evaluated by the Horner loop on the one
// shared multiplier, with a multiply and an add step for every term but the highest.
// Coefficient and term count writes are done in the idle state.
// After reset the term count store is cleared, one entry a cycle, and no item
// is taken while it is cleared.
// A two-entry queue lets the front end take items while the back end works.
// ----------------------------------------------------------------------------
module hit_calibrate_and_event_builder
   import hcb_pkg::*;
#(
   parameter int NUM_CHANNELS = 1024,
   parameter int MAX_TERMS    = 4
) (
   input  logic      clock,
   input  logic      reset,
   hcb_req_if.sink   req_bus,
   hcb_rsp_if.source rsp_bus,
   hcb_csr_if.sink   csr_bus
);

   logic [31:0]          window_ff;
   logic [SCATTER_W-1:0] scatter_ff;
   logic                 clearing;
   logic                 q_full;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_valid;
   item_type             q_in_item;
   item_type             q_head_item;
   logic                 csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         scatter_ff <= SCATTER_RESET;
      end else if (csr_write) begin
         case (csr_bus.index)
            REG_WINDOW:  window_ff  <= csr_bus.data;
            REG_SCATTER: scatter_ff <= csr_bus.data[SCATTER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hcb_front u_front (
      .reset           (reset),
      .req_bus         (req_bus),
      .scatter_channel (scatter_ff),
      .clearing        (clearing),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_in_item)
   );

   hcb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_in_item),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_item  (q_head_item)
   );

   hcb_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .MAX_TERMS    (MAX_TERMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_item  (q_head_item),
      .pop        (q_pop),
      .window_ps  (window_ff),
      .clearing   (clearing),
      .rsp_bus    (rsp_bus)
   );

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_bus.ready)
      else $error("item taken during term count clearing");

   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      q_full |-> q_valid)
      else $error("queue full and empty at once");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   a_window_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_bus.index == REG_WINDOW) |=> window_ff == $past(csr_bus.data))
      else $error("window register write lost");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hit calibrate and event builder testbench
// Drives hits, calibration writes and register writes with random idling on
// both channels, predicts every record and window summary, and compares each
// received transfer field by field in order.
// ----------------------------------------------------------------------------

class window_scoreboard;
   hcb_pkg::result_type pending[$];
   int errors = 0;
   logic [31:0] window_len = 32'd20000;
   logic [6:0] scatter_ch = 7'd21;
   logic signed [31:0] coefs [4096];
   logic [2:0] terms [1024];
   logic [47:0] win_start = 0;
   bit opened = 0;
   logic [15:0] n_total = 0, n_mod0 = 0, n_mod1 = 0;
   logic signed [47:0] acc_mod0 = 0, acc_mod1 = 0;
   logic signed [31:0] last_scatter = 0;

   function new();
      foreach (terms[i]) terms[i] = 0;
      foreach (coefs[i]) coefs[i] = 0;
   endfunction

   function logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function logic signed [47:0] add48(logic signed [47:0] s, logic signed [31:0] e);
      logic signed [63:0] r;
      r = 64'(s) + 64'(e);
      if (r > 64'sd140737488355327) return {1'b0, {47{1'b1}}};
      if (r < -64'sd140737488355328) return {1'b1, {47{1'b0}}};
      return r[47:0];
   endfunction

   function logic [15:0] bump(logic [15:0] c);
      return (&c) ? c : c + 16'd1;
   endfunction

   function logic signed [31:0] calibrated(logic [9:0] ch, logic [19:0] raw);
      int n;
      logic signed [63:0] acc, p;
      n = terms[ch];
      if (n == 0) return 0;
      acc = coefs[ch * 4 + n - 1];
      for (int i = n - 1; i > 0; i--) begin
         p = acc * $signed({44'd0, raw});
         acc = clamp32(p >>> 8);
         acc = clamp32(acc + 64'(coefs[ch * 4 + i - 1]));
      end
      return acc[31:0];
   endfunction

   function void note_item(hcb_pkg::item_type it);
      hcb_pkg::result_type r;
      logic signed [31:0] e;
      logic [1:0] m;
      if (it.mode == hcb_pkg::MODE_COEF) begin
         coefs[it.channel * 4 + it.term_index] = it.coef_value;
         return;
      end
      if (it.mode == hcb_pkg::MODE_TCNT) begin
         terms[it.channel] = (it.term_count > 4) ? 3'd4 : it.term_count;
         return;
      end
      if (it.mode != hcb_pkg::MODE_HIT) return;
      e = calibrated(it.channel, it.raw_energy);
      if (it.channel >= 256 && it.channel < 512) m = hcb_pkg::MOD_ZERO;
      else if (it.channel >= 512 && it.channel < 768) m = hcb_pkg::MOD_ONE;
      else if (it.channel == {3'd0, scatter_ch}) m = hcb_pkg::MOD_SCATTER;
      else m = hcb_pkg::MOD_NONE;
      if (!opened) begin
         opened = 1;
         win_start = it.time_ps;
      end
      if (49'(it.time_ps) > 49'(win_start) + 49'(window_len)) begin
         r = '0;
         r.kind = 1;
         r.module_res = hcb_pkg::MOD_NONE;
         r.time_value = win_start;
         r.offset_or_hits = 48'(n_total);
         r.energy_value = last_scatter;
         r.energy_module0 = acc_mod0;
         r.energy_module1 = acc_mod1;
         r.hits_module0 = n_mod0;
         r.hits_module1 = n_mod1;
         pending.insert(pending.size(), r);
         n_total = 0; n_mod0 = 0; n_mod1 = 0;
         acc_mod0 = 0; acc_mod1 = 0; last_scatter = 0;
         win_start = it.time_ps;
      end
      r = '0;
      r.channel_out = it.channel;
      r.module_res = m;
      r.column = hcb_pkg::COLUMN_ROM[it.channel[6:0]];
      r.row = hcb_pkg::ROW_ROM[it.channel[6:0]];
      r.time_value = it.time_ps;
      r.offset_or_hits = it.time_ps - win_start;
      r.energy_value = e;
      pending.insert(pending.size(), r);
      n_total = bump(n_total);
      if (m == hcb_pkg::MOD_ZERO) begin
         acc_mod0 = add48(acc_mod0, e);
         n_mod0 = bump(n_mod0);
      end else if (m == hcb_pkg::MOD_ONE) begin
         acc_mod1 = add48(acc_mod1, e);
         n_mod1 = bump(n_mod1);
      end else if (m == hcb_pkg::MOD_SCATTER) begin
         last_scatter = e;
      end
   endfunction

   function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0h actual %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_result(hcb_pkg::result_type a);
      hcb_pkg::result_type x;
      if (pending.size() == 0) begin
         $error("unexpected result transfer");
         errors++;
         return;
      end
      x = pending.pop_front();
      compare("kind", x.kind, a.kind);
      compare("channel_out", x.channel_out, a.channel_out);
      compare("module_res", x.module_res, a.module_res);
      compare("column", x.column, a.column);
      compare("row", x.row, a.row);
      compare("time_value", x.time_value, a.time_value);
      compare("offset_or_hits", x.offset_or_hits, a.offset_or_hits);
      compare("energy_value", x.energy_value, a.energy_value);
      compare("energy_module0", x.energy_module0, a.energy_module0);
      compare("energy_module1", x.energy_module1, a.energy_module1);
      compare("hits_module0", x.hits_module0, a.hits_module0);
      compare("hits_module1", x.hits_module1, a.hits_module1);
   endfunction
endclass

module tb_top;
   import hcb_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam logic [1:0] REG_SPARE = 2'd3;

   logic clock = 0;
   logic reset = 1;
   hcb_req_if req_bus ();
   hcb_rsp_if rsp_bus ();
   hcb_csr_if csr_bus ();

   window_scoreboard hits_sb = new();
   int send_idle = 0, take_idle = 0;
   int stall_cycles = 0;
   logic [47:0] clock_ps = 0;
   bit [1023:0] coef_written [4];

   hit_calibrate_and_event_builder dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   always #2 clock = ~clock;

   initial begin
      req_bus.valid = 0; req_bus.mode = 0; req_bus.channel = 0; req_bus.time_ps = 0;
      req_bus.raw_energy = 0; req_bus.term_index = 0; req_bus.coef_value = 0;
      req_bus.term_count = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0; csr_bus.index = 0; csr_bus.data = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp_bus.ready <= ($urandom_range(99) >= take_idle);
         if (rsp_bus.valid && rsp_bus.ready) begin
            hits_sb.check_result('{rsp_bus.kind, rsp_bus.channel_out, rsp_bus.module_res,
               rsp_bus.column, rsp_bus.row, rsp_bus.time_value, rsp_bus.offset_or_hits,
               rsp_bus.energy_value, rsp_bus.energy_module0, rsp_bus.energy_module1,
               rsp_bus.hits_module0, rsp_bus.hits_module1});
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // The valid flag stays high after a transfer so that the next item can
   // follow at once; idling and draining drop it.
   task automatic send_item(item_type it);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.mode <= it.mode;
      req_bus.channel <= it.channel;
      req_bus.time_ps <= it.time_ps;
      req_bus.raw_energy <= it.raw_energy;
      req_bus.term_index <= it.term_index;
      req_bus.coef_value <= it.coef_value;
      req_bus.term_count <= it.term_count;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      hits_sb.note_item(it);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 0;
      if (idx == REG_WINDOW) hits_sb.window_len = value;
      else if (idx == REG_SCATTER) hits_sb.scatter_ch = value[6:0];
      @(posedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (hits_sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_coef(logic [9:0] ch, logic [1:0] ti, logic [31:0] v);
      item_type it;
      it = '0;
      it.mode = MODE_COEF; it.channel = ch; it.term_index = ti; it.coef_value = v;
      it.time_ps = 48'({$urandom, $urandom});
      send_item(it);
      coef_written[ti][ch] = 1;
   endtask

   // The term count is only raised once every coefficient it uses was written.
   task automatic set_terms(logic [9:0] ch, logic [2:0] n);
      item_type it;
      int used;
      used = (n > 4) ? 4 : n;
      for (int i = 0; i < used; i++)
         if (!coef_written[i][ch]) set_coef(ch, i[1:0], $urandom);
      it = '0;
      it.mode = MODE_TCNT; it.channel = ch; it.term_count = n;
      it.raw_energy = 20'($urandom);
      send_item(it);
   endtask

   task automatic send_hit(logic [9:0] ch, logic [47:0] t, logic [19:0] raw);
      item_type it;
      it = '0;
      it.mode = MODE_HIT; it.channel = ch; it.time_ps = t; it.raw_energy = raw;
      it.term_index = 2'($urandom); it.coef_value = $urandom;
      it.term_count = 3'($urandom);
      send_item(it);
   endtask

   function automatic logic [9:0] pick_channel();
      case ($urandom_range(4))
         0: return 10'($urandom_range(256, 511));
         1: return 10'($urandom_range(512, 767));
         2: return {3'd0, hits_sb.scatter_ch};
         default: return 10'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count);
      item_type it;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(19))
            0: set_coef(10'($urandom), 2'($urandom), $urandom);
            1: set_terms(pick_channel(), 3'($urandom));
            2: begin
               it = item_type'($bits(item_type)'({$urandom, $urandom, $urandom,
                                                  $urandom, $urandom}));
               it.mode = MODE_NONE;
               send_item(it);
            end
            default: begin
               case ($urandom_range(9))
                  0: clock_ps = clock_ps - 48'($urandom_range(5000));
                  1: clock_ps = clock_ps + 48'(hits_sb.window_len);
                  2: clock_ps = clock_ps + 48'(hits_sb.window_len) + 48'd1;
                  3: clock_ps = clock_ps + {$urandom, 16'd0};
                  default: clock_ps = clock_ps + 48'($urandom_range(hits_sb.window_len / 3));
               endcase
               send_hit(pick_channel(), clock_ps,
                        ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      foreach (coef_written[i]) coef_written[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: extreme coefficients and raw energies, term counts 0, 2, 4 and 7.
      set_coef(10'd300, 2'd0, 32'h7FFF_FFFF);
      set_coef(10'd300, 2'd1, 32'h8000_0000);
      set_coef(10'd300, 2'd2, 32'h0001_0000);
      set_coef(10'd300, 2'd3, 32'h7FFF_FFFF);
      set_terms(10'd300, 3'd7);
      set_terms(10'd600, 3'd2);
      set_terms(10'd1023, 3'd4);
      send_hit(10'd300, 48'd100, 20'hFFFFF);
      send_hit(10'd600, 48'd120, 20'd0);
      send_hit(10'd21, 48'd20100, 20'd256);
      send_hit(10'd1023, 48'd20101, 20'hFFFFF);
      send_hit(10'd0, 48'd5, 20'd1);
      send_hit(10'd767, 48'd40200, 20'h12345);
      send_hit(10'd256, 48'hFFFF_FFFF_FFFF, 20'hFFFFF);
      send_hit(10'd511, 48'hFFFF_FFFF_FFFF, 20'd1);
      send_hit(10'd512, 48'd0, 20'd7);
      drain();
      write_reg(REG_WINDOW, 32'd0);
      write_reg(REG_SCATTER, 32'd127);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);

      send_idle = 23; take_idle = 79;
      clock_ps = 48'd1000;
      random_phase(500);
      drain();
      write_reg(REG_WINDOW, 32'hFFFF_FFFF);
      write_reg(REG_SCATTER, 32'd0);

      send_idle = 79; take_idle = 23;
      random_phase(500);
      drain();
      write_reg(REG_WINDOW, 32'd20000);
      write_reg(REG_SCATTER, 32'd21);

      send_idle = 0; take_idle = 0;
      random_phase(300);
      drain();
      write_reg(REG_WINDOW, 32'($urandom_range(100000)));
      write_reg(REG_SCATTER, 32'($urandom_range(127)));
      random_phase(300);
      drain();

      if (hits_sb.errors == 0 && hits_sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
